### hw/rtl/sks_pkg.sv
// Shared constants for the sorted key binary search block.
// Used by sorted_key_binary_search_top; depends on nothing else.
package sks_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int INDEX_W     = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = INDEX_W + 1;
  localparam int KEY_W       = 27;
  localparam int PROBE_W     = 5;

  localparam int IN_DATA_W   = ((INDEX_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((INDEX_W + PROBE_W + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);

  // Operation codes carried on in_tuser.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [PROBE_W-1:0] probe_t;

endpackage

### hw/rtl/sorted_key_binary_search_top.sv
// Sorted key table with a binary search engine over a one-write one-read synchronous memory.
// Depends on sks_pkg for widths, the table depth and the operation codes.
//
// Usage: keys are loaded in ascending order by write transfers (in_tuser low), each
// storing in_tdata's key at in_tdata's entry index; a write gives no result. A search
// transfer (in_tuser high) looks its key up over the first entry_count entries, set
// by the user through cfg_wen/cfg_wdata while the block is idle; the block does not check it.
// A search produces one result transfer: out_tuser is the found flag, out_tdata holds
// the matching index (zero when not found) and the number of table probes made.
// Each probe reads the key memory in the S_READ state (registered read data) and
// compares and halves the range in the S_CMP state. A search makes at most 17 probes
// for a full table of 65536 entries and stops early when it ends on a match; an
// empty table answers without any probe.
// The input is taken only while no search is in progress. A result waits in the
// output register while the receiver stalls; the next item is still accepted, but a
// further search holds its result back until the register has been emptied.
// Reset clears entry_count and the control state; the key memory is not cleared and
// entries must be written before they are searched.
module sorted_key_binary_search_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [sks_pkg::COUNT_W-1:0]    cfg_wdata,   // entry_count
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sks_pkg::IN_DATA_W-1:0]  in_tdata,    // entry_index, key_value, zero pad
  input  logic                           in_tuser,    // operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sks_pkg::OUT_DATA_W-1:0] out_tdata,   // found_index, probe_count, zero pad
  output logic                           out_tuser    // found
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int PAD_W = sks_pkg::OUT_DATA_W - sks_pkg::INDEX_W - sks_pkg::PROBE_W;

  sks_pkg::key_t key_mem [sks_pkg::TABLE_DEPTH];

  logic [1:0]      state_r, state_nxt;
  sks_pkg::count_t entry_count_r;
  sks_pkg::count_t lo_r, lo_nxt, hi_r, hi_nxt;
  sks_pkg::index_t mid_r, mid_nxt;
  sks_pkg::key_t   key_r, key_nxt;
  sks_pkg::probe_t probes_r, probes_nxt;
  logic            hit_r, hit_nxt;
  sks_pkg::key_t   rd_data_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_found_r;
  sks_pkg::index_t out_index_r;
  sks_pkg::probe_t out_probes_r;

  sks_pkg::index_t in_index;
  sks_pkg::key_t   in_key;
  logic            in_fire;
  logic            mem_we;
  sks_pkg::count_t span;
  sks_pkg::count_t mid_full;
  sks_pkg::count_t count_sat;
  logic            load_out;

  assign in_index = in_tdata[sks_pkg::INDEX_W-1:0];
  assign in_key   = in_tdata[sks_pkg::INDEX_W +: sks_pkg::KEY_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign mem_we    = in_fire && (in_tuser == sks_pkg::OP_WRITE);

  assign count_sat = (entry_count_r > sks_pkg::DEPTH_COUNT) ? sks_pkg::DEPTH_COUNT
                                                            : entry_count_r;
  assign span      = hi_r - lo_r;
  assign mid_full  = lo_r + (span >> 1);
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Key memory: one write port used by write transfers, one registered read for probes.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[in_index] <= in_key;
    end
    rd_data_r <= key_mem[mid_nxt];
  end

  always_comb begin
    state_nxt  = state_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    key_nxt    = key_r;
    probes_nxt = probes_r;
    hit_nxt    = hit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tuser == sks_pkg::OP_SEARCH)) begin
          lo_nxt     = '0;
          hi_nxt     = count_sat;
          key_nxt    = in_key;
          probes_nxt = '0;
          hit_nxt    = 1'b0;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        if (lo_r < hi_r) begin
          mid_nxt    = mid_full[sks_pkg::INDEX_W-1:0];
          probes_nxt = probes_r + sks_pkg::probe_t'(1);
          state_nxt  = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        if (key_r == rd_data_r) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          if (key_r < rd_data_r) begin
            hi_nxt = {1'b0, mid_r};
          end else begin
            lo_nxt = {1'b0, mid_r} + sks_pkg::count_t'(1);
          end
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        entry_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    key_r    <= key_nxt;
    probes_r <= probes_nxt;
    hit_r    <= hit_nxt;
    if (load_out) begin
      out_found_r  <= hit_r;
      out_index_r  <= hit_r ? mid_r : '0;
      out_probes_r <= probes_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_probes_r, out_index_r};

endmodule
